@@ design/hstw_pkg.sv @@
// Shared types and constants for the two-wire humidity sensor master.
// Used by hstw_csr, hstw_core and the top level; depends on nothing.
package hstw_pkg;

   localparam int CsrAddrWidth = 5;

   // register byte addresses, one 32-bit slot each
   localparam logic [CsrAddrWidth-1:0] REG_LOW_RES   = 5'h00;
   localparam logic [CsrAddrWidth-1:0] REG_NO_OTP    = 5'h04;
   localparam logic [CsrAddrWidth-1:0] REG_CRC_CHECK = 5'h08;
   localparam logic [CsrAddrWidth-1:0] REG_TIMEOUT   = 5'h0C;
   localparam logic [CsrAddrWidth-1:0] REG_TICKS     = 5'h10;

   // transaction status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_ACK  = 2'd1;
   localparam logic [1:0] ST_NO_RESP = 2'd2;
   localparam logic [1:0] ST_CRC_ERR = 2'd3;

   // sensor command bytes
   localparam logic [7:0] CMD_STATUS_WRITE = 8'h06;
   localparam logic [7:0] CMD_TEMP         = 8'h03;
   localparam logic [7:0] CMD_HUMI         = 8'h05;

   typedef struct packed {
      logic        low_resolution;
      logic        no_otp_reload;
      logic        crc_check;
      logic [7:0]  timeout_polls;
      logic [15:0] ticks_per_poll;
   } cfg_type;

   typedef struct packed {
      logic [15:0] measurement;
      logic [1:0]  result_status;
      logic        done_res;
      logic        busy_res;
      logic        data_drive_low;
      logic        clock_pin;
   } res_type;

endpackage

@@ design/hstw_csr.sv @@
// Configuration register file with an APB-style access port.
// Depends on hstw_pkg.
module hstw_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [hstw_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   output hstw_pkg::cfg_type                cfg
);
   import hstw_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr)
            REG_LOW_RES:   cfg_in.low_resolution = csr_pwdata[0];
            REG_NO_OTP:    cfg_in.no_otp_reload  = csr_pwdata[0];
            REG_CRC_CHECK: cfg_in.crc_check      = csr_pwdata[0];
            REG_TIMEOUT:   cfg_in.timeout_polls  = csr_pwdata[7:0];
            REG_TICKS:     cfg_in.ticks_per_poll = csr_pwdata[15:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_resolution <= 1'b0;
         cfg_ff.no_otp_reload  <= 1'b0;
         cfg_ff.crc_check      <= 1'b1;
         cfg_ff.timeout_polls  <= 8'd255;
         cfg_ff.ticks_per_poll <= 16'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_paddr)
         REG_LOW_RES:   csr_prdata = {31'd0, cfg_ff.low_resolution};
         REG_NO_OTP:    csr_prdata = {31'd0, cfg_ff.no_otp_reload};
         REG_CRC_CHECK: csr_prdata = {31'd0, cfg_ff.crc_check};
         REG_TIMEOUT:   csr_prdata = {24'd0, cfg_ff.timeout_polls};
         REG_TICKS:     csr_prdata = {16'd0, cfg_ff.ticks_per_poll};
         default:       csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ design/hstw_core.sv @@
// Bit-level protocol sequencer: one clock-line phase per tick word.
// Holds the transaction state; depends on hstw_pkg.
module hstw_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              cmd,
   input  logic [7:0]        code,
   input  logic              din,
   input  hstw_pkg::cfg_type cfg,
   output hstw_pkg::res_type res
);
   import hstw_pkg::*;

   localparam logic [4:0] PH_IDLE    = 5'd0;
   localparam logic [4:0] PH_WAKE_HI = 5'd1;
   localparam logic [4:0] PH_WAKE_LO = 5'd2;
   localparam logic [4:0] PH_ST0     = 5'd3;
   localparam logic [4:0] PH_ST6     = 5'd9;
   localparam logic [4:0] PH_W_SET   = 5'd10;
   localparam logic [4:0] PH_W_HI    = 5'd11;
   localparam logic [4:0] PH_ACK_SET = 5'd12;
   localparam logic [4:0] PH_ACK_HI  = 5'd13;
   localparam logic [4:0] PH_POLL    = 5'd14;
   localparam logic [4:0] PH_R_HI    = 5'd15;
   localparam logic [4:0] PH_R_LO    = 5'd16;
   localparam logic [4:0] PH_K_SET   = 5'd17;
   localparam logic [4:0] PH_K_HI    = 5'd18;
   localparam logic [4:0] PH_K_END   = 5'd19;
   localparam logic [4:0] PH_FIN     = 5'd20;  // +status code
   localparam logic [4:0] PH_FIN_LAST = 5'd23;

   // start sequence line levels, indexed by phase - PH_ST0
   localparam logic [6:0] START_CLK  = 7'b0110110;
   localparam logic [6:0] START_DLOW = 7'b0011100;

   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[i] = v[7-i];
      return r;
   endfunction

   function automatic logic [7:0] crc_upd(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++)
         c = c[7] ? ({c[6:0], 1'b0} ^ 8'h31) : {c[6:0], 1'b0};
      return c;
   endfunction

   logic        link_ready_ff, link_ready_in;
   logic [4:0]  phase_ff, phase_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [1:0]  byte_count_ff, byte_count_in;
   logic [7:0]  shift_byte_ff, shift_byte_in;
   logic [7:0]  held_command_ff, held_command_in;
   logic [7:0]  crc_accum_ff, crc_accum_in;
   logic [15:0] value_hold_ff, value_hold_in;
   logic [15:0] poll_tick_ff, poll_tick_in;
   logic [7:0]  poll_count_ff, poll_count_in;
   logic        ack_failed_ff, ack_failed_in;

   logic [1:0]  status_nib;
   logic [3:0]  bit_inc;
   logic [2:0]  st_idx;
   logic [15:0] meas;

   assign status_nib = {cfg.no_otp_reload, cfg.low_resolution};
   assign bit_inc    = bit_count_ff + 4'd1;
   assign st_idx     = 3'(phase_ff - PH_ST0);

   always_comb begin
      meas = value_hold_ff;
      if (cfg.low_resolution) begin
         if (held_command_ff == CMD_TEMP)      meas = {value_hold_ff[13:0], 2'b00};
         else if (held_command_ff == CMD_HUMI) meas = {value_hold_ff[11:0], 4'b0000};
      end
   end

   always_comb begin
      link_ready_in   = link_ready_ff;
      phase_in        = phase_ff;
      bit_count_in    = bit_count_ff;
      byte_count_in   = byte_count_ff;
      shift_byte_in   = shift_byte_ff;
      held_command_in = held_command_ff;
      crc_accum_in    = crc_accum_ff;
      value_hold_in   = value_hold_ff;
      poll_tick_in    = poll_tick_ff;
      poll_count_in   = poll_count_ff;
      ack_failed_in   = ack_failed_ff;
      res             = '0;
      res.busy_res    = 1'b1;

      if (phase_ff >= PH_ST0 && phase_ff <= PH_ST6) begin
         res.clock_pin      = START_CLK[st_idx];
         res.data_drive_low = START_DLOW[st_idx];
         if (phase_ff == PH_ST6) begin
            shift_byte_in = link_ready_ff ? held_command_ff : CMD_STATUS_WRITE;
            byte_count_in = 2'd0;
            bit_count_in  = 4'd0;
            phase_in      = PH_W_SET;
         end else begin
            phase_in = phase_ff + 5'd1;
         end
      end else if (phase_ff >= PH_FIN && phase_ff <= PH_FIN_LAST) begin
         res.busy_res      = 1'b0;
         res.done_res      = 1'b1;
         res.result_status = phase_ff[1:0];
         if (phase_ff[1:0] == ST_OK) res.measurement = meas;
         phase_in = PH_IDLE;
      end else begin
         case (phase_ff)
            PH_WAKE_HI: begin
               res.clock_pin = 1'b1;
               phase_in      = PH_WAKE_LO;
            end
            PH_WAKE_LO: begin
               if (bit_inc >= 4'd9) begin
                  bit_count_in = 4'd0;
                  phase_in     = PH_ST0;
               end else begin
                  bit_count_in = bit_inc;
                  phase_in     = PH_WAKE_HI;
               end
            end
            PH_W_SET: begin
               res.data_drive_low = !shift_byte_ff[7];
               phase_in           = PH_W_HI;
            end
            PH_W_HI: begin
               res.clock_pin      = 1'b1;
               res.data_drive_low = !shift_byte_ff[7];
               shift_byte_in      = {shift_byte_ff[6:0], 1'b0};
               if (bit_inc >= 4'd8) begin
                  bit_count_in = 4'd0;
                  phase_in     = PH_ACK_SET;
               end else begin
                  bit_count_in = bit_inc;
                  phase_in     = PH_W_SET;
               end
            end
            PH_ACK_SET: phase_in = PH_ACK_HI;
            PH_ACK_HI: begin
               res.clock_pin = 1'b1;
               if (!link_ready_ff) begin
                  if (din) ack_failed_in = 1'b1;
                  if (byte_count_ff == 2'd0) begin
                     byte_count_in = 2'd1;
                     shift_byte_in = {6'd0, status_nib};
                     phase_in      = PH_W_SET;
                  end else if (ack_failed_ff || din) begin
                     phase_in = PH_FIN + 5'(ST_NO_ACK);
                  end else begin
                     link_ready_in = 1'b1;
                     phase_in      = PH_ST0;
                  end
               end else if (din) begin
                  link_ready_in = 1'b0;
                  phase_in      = PH_FIN + 5'(ST_NO_ACK);
               end else begin
                  crc_accum_in  = crc_upd(rev8({6'd0, status_nib}), held_command_ff);
                  poll_tick_in  = 16'd0;
                  poll_count_in = 8'd0;
                  phase_in      = PH_POLL;
               end
            end
            PH_POLL: begin
               if (poll_tick_ff != 16'd0) begin
                  poll_tick_in = poll_tick_ff - 16'd1;
               end else if (!din) begin
                  bit_count_in  = 4'd0;
                  byte_count_in = 2'd0;
                  shift_byte_in = 8'd0;
                  phase_in      = PH_R_HI;
               end else if (poll_count_ff >= cfg.timeout_polls) begin
                  link_ready_in = 1'b0;
                  phase_in      = PH_FIN + 5'(ST_NO_RESP);
               end else begin
                  poll_count_in = poll_count_ff + 8'd1;
                  poll_tick_in  = (cfg.ticks_per_poll == 16'd0) ? 16'd0 :
                                  cfg.ticks_per_poll - 16'd1;
               end
            end
            PH_R_HI: begin
               res.clock_pin = 1'b1;
               shift_byte_in = {shift_byte_ff[6:0], din};
               phase_in      = PH_R_LO;
            end
            PH_R_LO: begin
               if (bit_inc >= 4'd8) begin
                  bit_count_in = 4'd0;
                  phase_in     = PH_K_SET;
               end else begin
                  bit_count_in = bit_inc;
                  phase_in     = PH_R_HI;
               end
            end
            PH_K_SET: begin
               res.data_drive_low = byte_count_ff < 2'd2;
               phase_in           = PH_K_HI;
            end
            PH_K_HI: begin
               res.clock_pin      = 1'b1;
               res.data_drive_low = byte_count_ff < 2'd2;
               phase_in           = PH_K_END;
            end
            PH_K_END: begin
               if (byte_count_ff < 2'd2) begin
                  crc_accum_in  = crc_upd(crc_accum_ff, shift_byte_ff);
                  value_hold_in = {value_hold_ff[7:0], shift_byte_ff};
                  byte_count_in = byte_count_ff + 2'd1;
                  shift_byte_in = 8'd0;
                  phase_in      = PH_R_HI;
               end else if (cfg.crc_check && crc_accum_ff != rev8(shift_byte_ff)) begin
                  link_ready_in = 1'b0;
                  phase_in      = PH_FIN + 5'(ST_CRC_ERR);
               end else begin
                  phase_in = PH_FIN;
               end
            end
            default: begin
               // idle and unused codes
               phase_in = PH_IDLE;
               if (cmd) begin
                  held_command_in = code;
                  ack_failed_in   = 1'b0;
                  bit_count_in    = 4'd0;
                  byte_count_in   = 2'd0;
                  phase_in        = link_ready_ff ? PH_ST0 : PH_WAKE_HI;
               end else begin
                  res.busy_res = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ready_ff   <= 1'b0;
         phase_ff        <= PH_IDLE;
         bit_count_ff    <= 4'd0;
         byte_count_ff   <= 2'd0;
         shift_byte_ff   <= 8'd0;
         held_command_ff <= 8'd0;
         crc_accum_ff    <= 8'd0;
         value_hold_ff   <= 16'd0;
         poll_tick_ff    <= 16'd0;
         poll_count_ff   <= 8'd0;
         ack_failed_ff   <= 1'b0;
      end else if (step) begin
         link_ready_ff   <= link_ready_in;
         phase_ff        <= phase_in;
         bit_count_ff    <= bit_count_in;
         byte_count_ff   <= byte_count_in;
         shift_byte_ff   <= shift_byte_in;
         held_command_ff <= held_command_in;
         crc_accum_ff    <= crc_accum_in;
         value_hold_ff   <= value_hold_in;
         poll_tick_ff    <= poll_tick_in;
         poll_count_ff   <= poll_count_in;
         ack_failed_ff   <= ack_failed_in;
      end
   end

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (step && res.done_res) |-> !res.busy_res)
      else $error("done word still flagged busy");

   a_meas_only_ok: assert property (@(posedge clock) disable iff (reset)
      (step && res.measurement != 16'd0) |-> (res.done_res && res.result_status == ST_OK))
      else $error("measurement outside a good finish");

   a_fin_to_idle: assert property (@(posedge clock) disable iff (reset)
      (step && phase_ff >= PH_FIN && phase_ff <= PH_FIN_LAST) |=> (phase_ff == PH_IDLE))
      else $error("finish phase did not return to idle");

endmodule

@@ design/humidity_sensor_two_wire_master_top.sv @@
// Top level of the two-wire humidity sensor master: input register, result register.
// Depends on hstw_pkg, hstw_csr and hstw_core.
//
// Each request word is one phase of the sensor clock line and yields exactly one
// result word carrying the line levels and status for that phase. A new word is
// taken every cycle while the result register can drain; a word passes an input
// register and then the result register, which a stalled receiver holds. The rate
// is one word per cycle unless rsp_tready holds the flow. A full measurement spans
// many words: 18 wake phases if the link is down, start sequences, status-write and
// command bytes, polling paced by ticks_per_poll, then three read bytes.
module humidity_sensor_two_wire_master_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [15:0]                      req_tdata,   // measure_code[7:0], data_pin[8]
   input  logic                             req_tuser,   // command
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // clock_pin[0], data_drive_low[1], busy_res[2], done_res[3],
   // result_status[5:4], measurement[21:6]
   output logic [23:0]                      rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [hstw_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import hstw_pkg::*;

   cfg_type     cfg;
   res_type     res;
   logic        in_valid_ff, in_valid_in;
   logic        in_cmd_ff;
   logic [7:0]  in_code_ff;
   logic        in_din_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   res_type     res_ff;
   logic        advance;
   logic        req_take;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : ((rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff);

   hstw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hstw_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .cmd   (in_cmd_ff),
      .code  (in_code_ff),
      .din   (in_din_ff),
      .cfg   (cfg),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff  <= req_tuser;
         in_code_ff <= req_tdata[7:0];
         in_din_ff  <= req_tdata[8];
      end
      if (advance) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, res_ff.measurement, res_ff.result_status, res_ff.done_res,
                        res_ff.busy_res, res_ff.data_drive_low, res_ff.clock_pin};

   a_in_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("stalled input word lost");

   a_adv_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed word not presented");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("empty input register refuses words");

endmodule

@@ test/tb.sv @@
// Testbench for humidity_sensor_two_wire_master_top: drives tick words, checks result words.
// Depends on hstw_pkg and the design; the sensor on the far side of the link is emulated
// here, and each result is checked against a phase-by-phase predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hstw_pkg::*;

   localparam logic [4:0] PH_IDLE        = 5'd0;
   localparam logic [4:0] PH_WAKE_HI     = 5'd1;
   localparam logic [4:0] PH_WAKE_LO     = 5'd2;
   localparam logic [4:0] PH_ST0         = 5'd3;
   localparam logic [4:0] PH_ST6         = 5'd9;
   localparam logic [4:0] PH_W_SET       = 5'd10;
   localparam logic [4:0] PH_W_HI        = 5'd11;
   localparam logic [4:0] PH_ACK_SET     = 5'd12;
   localparam logic [4:0] PH_ACK_HI      = 5'd13;
   localparam logic [4:0] PH_POLL        = 5'd14;
   localparam logic [4:0] PH_R_HI        = 5'd15;
   localparam logic [4:0] PH_R_LO        = 5'd16;
   localparam logic [4:0] PH_K_SET       = 5'd17;
   localparam logic [4:0] PH_K_HI        = 5'd18;
   localparam logic [4:0] PH_K_END       = 5'd19;
   localparam logic [4:0] PH_FIN_OK      = 5'd20;
   localparam logic [4:0] PH_FIN_NO_ACK  = 5'd21;
   localparam logic [4:0] PH_FIN_NO_RESP = 5'd22;
   localparam logic [4:0] PH_FIN_CRC     = 5'd23;

   // start sequence line levels, step 0 in bit 0
   localparam logic [6:0] START_CLK  = 7'b0110110;
   localparam logic [6:0] START_DLOW = 7'b0011100;

   class phase_word_scoreboard;
      bit        low_res, no_otp, crc_on;
      bit [7:0]  max_polls;
      bit [15:0] poll_ticks;
      bit        link_up, ack_bad;
      bit [4:0]  phase;
      bit [3:0]  bit_cnt;
      bit [1:0]  byte_cnt;
      bit [7:0]  shreg, cmd_byte, crc, poll_cnt;
      bit [15:0] value, tick_cnt;
      res_type   levels_due[$];
      int        errors, checked, finished;
      int        status_seen[4];

      function new();
         low_res = 0; no_otp = 0; crc_on = 1; max_polls = 255; poll_ticks = 1000;
         link_up = 0; ack_bad = 0; phase = PH_IDLE; bit_cnt = 0; byte_cnt = 0;
         shreg = 0; cmd_byte = 0; crc = 0; poll_cnt = 0; value = 0; tick_cnt = 0;
      endfunction

      function bit [7:0] rev8(bit [7:0] v);
         bit [7:0] r;
         for (int i = 0; i < 8; i++) r[7-i] = v[i];
         return r;
      endfunction

      function bit [7:0] crc_step(bit [7:0] c, bit [7:0] b);
         c = c ^ b;
         for (int i = 0; i < 8; i++) c = c[7] ? ((c << 1) ^ 8'h31) : (c << 1);
         return c;
      endfunction

      function void set_reg(logic [CsrAddrWidth-1:0] addr, logic [31:0] v);
         case (addr)
            REG_LOW_RES:   low_res = v[0];
            REG_NO_OTP:    no_otp = v[0];
            REG_CRC_CHECK: crc_on = v[0];
            REG_TIMEOUT:   max_polls = v[7:0];
            REG_TICKS:     poll_ticks = v[15:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return levels_due.size();
      endfunction

      // advance one clock-line phase and queue the levels it produces
      function void take_request(bit go, bit [7:0] code, bit pin);
         res_type   r;
         bit [4:0]  p;
         bit [15:0] m;
         r = '0;
         r.busy_res = 1;
         p = phase;
         if (p >= PH_ST0 && p <= PH_ST6) begin
            r.clock_pin = START_CLK[p - PH_ST0];
            r.data_drive_low = START_DLOW[p - PH_ST0];
            if (p == PH_ST6) begin
               shreg = link_up ? cmd_byte : CMD_STATUS_WRITE;
               byte_cnt = 0;
               bit_cnt = 0;
               phase = PH_W_SET;
            end else begin
               phase = p + 5'd1;
            end
         end else if (p >= PH_FIN_OK && p <= PH_FIN_CRC) begin
            r.busy_res = 0;
            r.done_res = 1;
            r.result_status = 2'(p - PH_FIN_OK);
            if (p == PH_FIN_OK) begin
               m = value;
               if (low_res && cmd_byte == CMD_TEMP) m = m << 2;
               else if (low_res && cmd_byte == CMD_HUMI) m = m << 4;
               r.measurement = m;
            end
            phase = PH_IDLE;
         end else begin
            case (p)
               PH_WAKE_HI: begin
                  r.clock_pin = 1;
                  phase = PH_WAKE_LO;
               end
               PH_WAKE_LO: begin
                  bit_cnt++;
                  if (bit_cnt >= 9) begin
                     bit_cnt = 0;
                     phase = PH_ST0;
                  end else begin
                     phase = PH_WAKE_HI;
                  end
               end
               PH_W_SET: begin
                  r.data_drive_low = ~shreg[7];
                  phase = PH_W_HI;
               end
               PH_W_HI: begin
                  r.clock_pin = 1;
                  r.data_drive_low = ~shreg[7];
                  shreg = shreg << 1;
                  bit_cnt++;
                  if (bit_cnt >= 8) begin
                     bit_cnt = 0;
                     phase = PH_ACK_SET;
                  end else begin
                     phase = PH_W_SET;
                  end
               end
               PH_ACK_SET: phase = PH_ACK_HI;
               PH_ACK_HI: begin
                  r.clock_pin = 1;
                  if (!link_up) begin
                     if (pin) ack_bad = 1;
                     if (byte_cnt == 0) begin
                        byte_cnt = 1;
                        shreg = {6'b0, no_otp, low_res};
                        phase = PH_W_SET;
                     end else if (ack_bad) begin
                        phase = PH_FIN_NO_ACK;
                     end else begin
                        link_up = 1;
                        phase = PH_ST0;
                     end
                  end else if (pin) begin
                     link_up = 0;
                     phase = PH_FIN_NO_ACK;
                  end else begin
                     crc = crc_step(rev8({6'b0, no_otp, low_res}), cmd_byte);
                     tick_cnt = 0;
                     poll_cnt = 0;
                     phase = PH_POLL;
                  end
               end
               PH_POLL: begin
                  if (tick_cnt != 0) begin
                     tick_cnt--;
                  end else if (!pin) begin
                     bit_cnt = 0;
                     byte_cnt = 0;
                     shreg = 0;
                     phase = PH_R_HI;
                  end else if (poll_cnt >= max_polls) begin
                     link_up = 0;
                     phase = PH_FIN_NO_RESP;
                  end else begin
                     poll_cnt++;
                     tick_cnt = (poll_ticks == 16'd0) ? 16'd0 : poll_ticks - 16'd1;
                  end
               end
               PH_R_HI: begin
                  r.clock_pin = 1;
                  shreg = {shreg[6:0], pin};
                  phase = PH_R_LO;
               end
               PH_R_LO: begin
                  bit_cnt++;
                  if (bit_cnt >= 8) begin
                     bit_cnt = 0;
                     phase = PH_K_SET;
                  end else begin
                     phase = PH_R_HI;
                  end
               end
               PH_K_SET: begin
                  r.data_drive_low = (byte_cnt < 2);
                  phase = PH_K_HI;
               end
               PH_K_HI: begin
                  r.clock_pin = 1;
                  r.data_drive_low = (byte_cnt < 2);
                  phase = PH_K_END;
               end
               PH_K_END: begin
                  if (byte_cnt < 2) begin
                     crc = crc_step(crc, shreg);
                     value = {value[7:0], shreg};
                     byte_cnt++;
                     shreg = 0;
                     phase = PH_R_HI;
                  end else if (crc_on && crc != rev8(shreg)) begin
                     link_up = 0;
                     phase = PH_FIN_CRC;
                  end else begin
                     phase = PH_FIN_OK;
                  end
               end
               default: begin
                  // idle, and any unused phase code
                  phase = PH_IDLE;
                  if (go) begin
                     cmd_byte = code;
                     ack_bad = 0;
                     bit_cnt = 0;
                     byte_cnt = 0;
                     phase = link_up ? PH_ST0 : PH_WAKE_HI;
                  end else begin
                     r.busy_res = 0;
                  end
               end
            endcase
         end
         levels_due.push_back(r);
      endfunction

      function void compare(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void match_levels(logic [23:0] d);
         res_type want, got;
         if (levels_due.size() == 0) begin
            $error("result word %0h with nothing expected", d);
            errors++;
            return;
         end
         want = levels_due.pop_front();
         got = res_type'(d[21:0]);
         compare("clock_pin", want.clock_pin, got.clock_pin);
         compare("data_drive_low", want.data_drive_low, got.data_drive_low);
         compare("busy_res", want.busy_res, got.busy_res);
         compare("done_res", want.done_res, got.done_res);
         compare("result_status", want.result_status, got.result_status);
         compare("measurement", want.measurement, got.measurement);
         checked++;
         if (want.done_res) begin
            finished++;
            status_seen[want.result_status]++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // measure_code[7:0], data_pin[8]
   logic        req_tuser = 1'b0; // command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // clock_pin[0], data_drive_low[1], busy_res[2], done_res[3],
   // result_status[5:4], measurement[21:6]
   logic [23:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   phase_word_scoreboard sb = new();

   int        burst_left = 0;
   int        poll_low_pct = 100;
   bit [23:0] frame = '0;   // msb, lsb, crc byte the emulated sensor sends

   humidity_sensor_two_wire_master_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.match_levels(rsp_tdata);
   end

   // data line level the sensor shows for the phase about to run
   function automatic bit sensor_pin();
      int idx;
      case (sb.phase)
         PH_ACK_HI: return $urandom_range(99) < 6;
         PH_POLL:   return $urandom_range(99) >= poll_low_pct;
         PH_R_HI: begin
            idx = 23 - (sb.byte_cnt * 8 + sb.bit_cnt);
            return frame[idx] ^ ($urandom_range(99) < 2);
         end
         default:   return 1'($urandom_range(1));
      endcase
   endfunction

   task automatic send_word(input bit go, input bit [7:0] code, input bit pin);
      bit [4:0] was;
      int       gap;
      bit [7:0] hi, lo, chk;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(99) < 30) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      was = sb.phase;
      req_tvalid <= 1'b1;
      req_tuser <= go;
      req_tdata <= {7'b0, pin, code};
      do @(posedge clock); while (!req_tready);
      sb.take_request(go, code, pin);
      // conversion done: sensor prepares its three bytes, crc correct most of the time
      if (was == PH_POLL && sb.phase == PH_R_HI) begin
         hi = 8'($urandom);
         lo = 8'($urandom);
         chk = sb.rev8(sb.crc_step(sb.crc_step(sb.crc, hi), lo));
         if ($urandom_range(99) < 8) chk ^= 8'(1 << $urandom_range(7));
         frame = {hi, lo, chk};
      end
   endtask

   task automatic next_word(input bit allow_start);
      bit       go;
      bit [7:0] code;
      int       chance;
      chance = (sb.phase >= PH_FIN_OK && sb.phase <= PH_FIN_CRC) ? 50 : 25;
      go = allow_start && ($urandom_range(99) < chance);
      if ($urandom_range(1)) code = $urandom_range(1) ? CMD_TEMP : CMD_HUMI;
      else code = 8'($urandom);
      send_word(go, code, sensor_pin());
   endtask

   task automatic csr_write(input logic [CsrAddrWidth-1:0] addr, input logic [31:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.set_reg(addr, v);
   endtask

   // receiver: stall patterns, plus one long hold-off so the block backs up
   initial begin : rsp_side
      int       mode;
      bit [7:0] pat;
      bit       held_off;
      held_off = 0;
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && sb.checked >= 300) begin
            held_off = 1;
            rsp_tready <= 1'b0;
            repeat (80) @(posedge clock);
         end
         mode = $urandom_range(2);
         pat = 8'($urandom);
         for (int k = 0; k < 24; k++) begin
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= pat[k % 8];
               default: rsp_tready <= 1'($urandom_range(1));
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      bit        lr, no, cc;
      bit [7:0]  tp;
      bit [15:0] tk;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // field extremes, a start on a down link, then requests while busy
      send_word(1'b0, 8'h00, 1'b0);
      send_word(1'b0, 8'hFF, 1'b1);
      send_word(1'b1, CMD_TEMP, 1'b0);
      send_word(1'b1, 8'hFF, 1'b1);
      send_word(1'b1, 8'h00, 1'b0);
      repeat (15) send_word(1'b1, 8'($urandom), sensor_pin());

      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            req_tvalid <= 1'b0;
            burst_left = 0;
            while (sb.pending() != 0) @(posedge clock);
            case (ph)
               1: begin
                  lr = 1; no = 0; cc = 1; tp = 1; tk = 1; poll_low_pct = 30;
               end
               2: begin
                  lr = 0; no = 1; cc = 0; tp = 3; tk = 2; poll_low_pct = 40;
               end
               3: begin
                  lr = 1; no = 1; cc = 1; tp = 255; tk = 16'hFFFF; poll_low_pct = 100;
               end
               4: begin
                  lr = 1'($urandom_range(1));
                  no = 1'($urandom_range(1));
                  cc = 1'($urandom_range(1));
                  tp = 8'($urandom_range(1, 12));
                  tk = 16'($urandom_range(1, 5));
                  poll_low_pct = 25;
               end
               default: begin
                  lr = 1; no = 0; cc = 1; tp = 255; tk = 1; poll_low_pct = 15;
               end
            endcase
            csr_write(REG_LOW_RES, {31'b0, lr});
            csr_write(REG_NO_OTP, {31'b0, no});
            csr_write(REG_CRC_CHECK, {31'b0, cc});
            csr_write(REG_TIMEOUT, {24'b0, tp});
            csr_write(REG_TICKS, {16'b0, tk});
         end
         repeat (140) next_word(1'b1);
         // finish the transaction in flight so the next settings land on an idle block
         while (sb.phase != PH_IDLE) next_word(1'b0);
      end

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Checked %0d result words over 6 register settings, %0d transactions finished",
               sb.checked, sb.finished);
      $display("  status ok %0d, no ack %0d, no response %0d, crc mismatch %0d",
               sb.status_seen[ST_OK], sb.status_seen[ST_NO_ACK],
               sb.status_seen[ST_NO_RESP], sb.status_seen[ST_CRC_ERR]);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
